// ===== rtl/mono_bit_rle_bitmap_decoder_defines.svh =====
// assertion macros used by the bitmap decoder datapath
`ifndef MONO_BIT_RLE_BITMAP_DECODER_DEFINES_SVH
`define MONO_BIT_RLE_BITMAP_DECODER_DEFINES_SVH

// same-cycle implication, clocked on clock, off during reset
`define MBRLE_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define MBRLE_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/mbrle_pkg.sv =====
// types and constants of the run-length bitmap decoder
`default_nettype none
package mbrle_pkg;

   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 2048;

   localparam int BYTE_W     = 8;
   localparam int ADDR_W     = 19;
   localparam int CFG_DATA_W = 12;
   localparam int STRIDE_W   = 9;
   localparam int RUN_W      = 9;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CFG_DATA_W-1:0] RST_WIDTH  = 12'd144;
   localparam logic [CFG_DATA_W-1:0] RST_HEIGHT = 12'd168;
   localparam logic [STRIDE_W-1:0]   RST_STRIDE = 9'd20;

   localparam int MIN_WIDTH  = 16;
   localparam int MIN_HEIGHT = 1;

   localparam logic [RUN_W-1:0] LONG_RUN    = 9'd258;
   localparam logic [RUN_W-1:0] EXT_BIAS    = 9'd3;
   localparam logic [1:0]       TOK_EXT     = 2'd3;
   localparam logic [2:0]       PAIRS_BYTE  = 3'd4;
   localparam logic [1:0]       EXT_LAST_PR = 2'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_STRIDE = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_TOKEN  = 3'd1,
      PH_EXT    = 3'd2,
      PH_DONE   = 3'd3,
      PH_ERROR  = 3'd4
   } phase_type;

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_PARSE = 1'b1
   } step_state_type;

   typedef struct packed {
      logic load;
      logic header;
      logic pair;
      logic chunk;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      phase_type phase;
      logic      run_busy;
      logic      pairs_zero;
      logic      chunk_emits;
      logic      hold_valid;
      logic      slot_free;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== rtl/mbrle_if.sv =====
// channel interfaces: compressed byte input, bitmap result output, register writes
`default_nettype none
interface mbrle_req_if;
   import mbrle_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;
   modport source (output valid, data_byte, last_byte, input ready);
   modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface mbrle_rsp_if;
   import mbrle_pkg::*;
   logic              valid;
   logic              ready;
   logic              byte_valid;
   logic [ADDR_W-1:0] byte_address;
   logic [BYTE_W-1:0] byte_value;
   logic              image_done;
   logic              stream_error;
   logic              last_result;
   modport source (output valid, byte_valid, byte_address, byte_value, image_done,
                   stream_error, last_result, input ready);
   modport sink (input valid, byte_valid, byte_address, byte_value, image_done,
                 stream_error, last_result, output ready);
endinterface

interface mbrle_csr_if;
   import mbrle_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CFG_DATA_W-1:0] wr_data;
   modport source (output valid, reg_index, wr_data, input ready);
   modport sink (input valid, reg_index, wr_data, output ready);
endinterface
`default_nettype wire

// ===== rtl/mbrle_csr.sv =====
// configuration registers: image width, height and row stride
`default_nettype none
module mbrle_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            wr_valid,
   output logic                                 wr_ready,
   input  wire logic [mbrle_pkg::CSR_IDX_W-1:0]  wr_index,
   input  wire logic [mbrle_pkg::CFG_DATA_W-1:0] wr_data,
   output logic [mbrle_pkg::CFG_DATA_W-1:0]      cfg_width,
   output logic [mbrle_pkg::CFG_DATA_W-1:0]      cfg_height,
   output logic [mbrle_pkg::STRIDE_W-1:0]        cfg_stride
);
   import mbrle_pkg::*;

   logic [CFG_DATA_W-1:0] width_ff, width_in;
   logic [CFG_DATA_W-1:0] height_ff, height_in;
   logic [STRIDE_W-1:0]   stride_ff, stride_in;

   assign wr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      stride_in = stride_ff;
      if (wr_valid) begin
         unique case (wr_index)
            CSR_WIDTH:  width_in  = wr_data;
            CSR_HEIGHT: height_in = wr_data;
            CSR_STRIDE: stride_in = wr_data[STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_WIDTH;
         height_ff <= RST_HEIGHT;
         stride_ff <= RST_STRIDE;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         stride_ff <= stride_in;
      end
   end

   assign cfg_width  = width_ff;
   assign cfg_height = height_ff;
   assign cfg_stride = stride_ff;

endmodule
`default_nettype wire

// ===== rtl/mbrle_ctrl.sv =====
// step controller: sequences accept, header, token pairs, run chunks and closing result
`default_nettype none
module mbrle_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire mbrle_pkg::dp_status_type status,
   output mbrle_pkg::dp_cmd_type         cmd
);
   import mbrle_pkg::*;

   step_state_type state_ff, state_in;
   logic           stall_chunk;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd         = '0;
      req_ready   = 1'b0;
      state_in    = state_ff;
      stall_chunk = status.chunk_emits && status.hold_valid && !status.slot_free;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PARSE;
            end
         end
         ST_PARSE: begin
            if (status.phase == PH_HEADER) begin
               cmd.header = 1'b1;
            end else if (status.run_busy) begin
               cmd.chunk = !stall_chunk;
            end else if (status.pairs_zero || status.phase == PH_DONE ||
                         status.phase == PH_ERROR) begin
               if (status.slot_free) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               cmd.pair = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/mbrle_dpath.sv =====
// datapath: token parsing, pixel packing, address generation and result registers
`default_nettype none
`include "mono_bit_rle_bitmap_decoder_defines.svh"
module mbrle_dpath #(
   parameter int MAX_WIDTH  = mbrle_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = mbrle_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire mbrle_pkg::dp_cmd_type           cmd,
   output mbrle_pkg::dp_status_type             status,
   input  wire logic [mbrle_pkg::BYTE_W-1:0]     req_data,
   input  wire logic                            req_last,
   input  wire logic [mbrle_pkg::CFG_DATA_W-1:0] cfg_width,
   input  wire logic [mbrle_pkg::CFG_DATA_W-1:0] cfg_height,
   input  wire logic [mbrle_pkg::STRIDE_W-1:0]   cfg_stride,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_valid,
   output logic                                 rsp_byte_valid,
   output logic [mbrle_pkg::ADDR_W-1:0]          rsp_address,
   output logic [mbrle_pkg::BYTE_W-1:0]          rsp_value,
   output logic                                 rsp_done,
   output logic                                 rsp_error,
   output logic                                 rsp_last
);
   import mbrle_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);

   // stream state
   phase_type          phase_ff, phase_in;
   logic               color_ff, color_in;
   logic [5:0]         tok_ff, tok_in;
   logic [1:0]         tok_cnt_ff, tok_cnt_in;
   logic [RUN_W-1:0]   run_ff, run_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [BYTE_W-1:0]  pend_ff, pend_in;
   logic [2:0]         pairs_ff, pairs_in;
   logic               hold_valid_ff, hold_valid_in;
   logic               out_valid_ff, out_valid_in;

   // payload
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic               last_ff, last_in;
   logic               run_color_ff, run_color_in;
   logic [CW-1:0]      w_ff, w_in;
   logic [RW-1:0]      h_ff, h_in;
   logic [STRIDE_W-1:0] stride_ff, stride_in;
   logic [ADDR_W-1:0]  hold_addr_ff, hold_addr_in;
   logic [BYTE_W-1:0]  hold_value_ff, hold_value_in;
   logic               hold_done_ff, hold_done_in;
   logic               out_bvalid_ff, out_bvalid_in;
   logic [ADDR_W-1:0]  out_addr_ff, out_addr_in;
   logic [BYTE_W-1:0]  out_value_ff, out_value_in;
   logic               out_done_ff, out_done_in;
   logic               out_err_ff, out_err_in;
   logic               out_last_ff, out_last_in;

   // chunk terms
   logic [2:0]         col_lo;
   logic [3:0]         room_byte;
   logic [CW-1:0]      room_row;
   logic [3:0]         chunk_n;
   logic [3:0]         end_lo;
   logic [BYTE_W-1:0]  chunk_mask;
   logic [BYTE_W-1:0]  pend_new;
   logic [CW-1:0]      col_new;
   logic               row_end;
   logic               byte_end;
   logic               last_row;
   logic [ADDR_W-1:0]  chunk_addr;

   // pair and header terms
   logic [1:0]         pair_bits;
   logic [7:0]         ext_val;
   logic [12:0]        w_raw;
   logic [12:0]        w_sel;
   logic [12:0]        h_raw;
   logic [12:0]        h_sel;
   logic [13:0]        need_bytes;
   logic               stride_short;
   logic               fin_err;
   logic               slot_free;

   always_comb begin
      col_lo     = col_ff[2:0];
      room_byte  = 4'd8 - {1'b0, col_lo};
      room_row   = w_ff - col_ff;
      chunk_n    = room_byte;
      if (run_ff < RUN_W'(chunk_n)) begin
         chunk_n = run_ff[3:0];
      end
      if (room_row < CW'(chunk_n)) begin
         chunk_n = room_row[3:0];
      end
      end_lo     = {1'b0, col_lo} + chunk_n;
      chunk_mask = (8'hFF >> col_lo) & ~(8'hFF >> end_lo);
      pend_new   = pend_ff | ({BYTE_W{run_color_ff}} & chunk_mask);
      col_new    = col_ff + CW'(chunk_n);
      row_end    = (col_new == w_ff);
      byte_end   = (end_lo == 4'd8) || row_end;
      last_row   = (row_ff == h_ff - RW'(1));
      chunk_addr = base_ff + ADDR_W'(col_ff >> 3);

      pair_bits  = byte_ff[7:6];
      ext_val    = {tok_ff, pair_bits};

      w_raw = {1'b0, cfg_width};
      if (w_raw < 13'(MIN_WIDTH)) begin
         w_sel = 13'(MIN_WIDTH);
      end else if (w_raw > 13'(MAX_WIDTH)) begin
         w_sel = 13'(MAX_WIDTH);
      end else begin
         w_sel = w_raw;
      end
      h_raw = {1'b0, cfg_height};
      if (h_raw < 13'(MIN_HEIGHT)) begin
         h_sel = 13'(MIN_HEIGHT);
      end else if (h_raw > 13'(MAX_HEIGHT)) begin
         h_sel = 13'(MAX_HEIGHT);
      end else begin
         h_sel = h_raw;
      end
      need_bytes   = (14'(w_sel) + 14'd7) >> 3;
      stride_short = 14'(cfg_stride) < need_bytes;

      fin_err   = (phase_ff == PH_ERROR) ||
                  (last_ff && (phase_ff == PH_TOKEN || phase_ff == PH_EXT));
      slot_free = !out_valid_ff || rsp_ready;
   end

   always_comb begin
      phase_in      = phase_ff;
      color_in      = color_ff;
      tok_in        = tok_ff;
      tok_cnt_in    = tok_cnt_ff;
      run_in        = run_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      base_in       = base_ff;
      pend_in       = pend_ff;
      pairs_in      = pairs_ff;
      hold_valid_in = hold_valid_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      byte_in       = byte_ff;
      last_in       = last_ff;
      run_color_in  = run_color_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      stride_in     = stride_ff;
      hold_addr_in  = hold_addr_ff;
      hold_value_in = hold_value_ff;
      hold_done_in  = hold_done_ff;
      out_bvalid_in = out_bvalid_ff;
      out_addr_in   = out_addr_ff;
      out_value_in  = out_value_ff;
      out_done_in   = out_done_ff;
      out_err_in    = out_err_ff;
      out_last_in   = out_last_ff;

      if (cmd.load) begin
         byte_in  = req_data;
         last_in  = req_last;
         pairs_in = PAIRS_BYTE;
      end else if (cmd.header) begin
         w_in       = CW'(w_sel);
         h_in       = RW'(h_sel);
         stride_in  = cfg_stride;
         color_in   = byte_ff[0];
         tok_in     = '0;
         tok_cnt_in = '0;
         run_in     = '0;
         col_in     = '0;
         row_in     = '0;
         base_in    = '0;
         pend_in    = '0;
         pairs_in   = '0;
         phase_in   = stride_short ? PH_ERROR : PH_TOKEN;
      end else if (cmd.pair) begin
         byte_in  = {byte_ff[5:0], 2'b00};
         pairs_in = pairs_ff - 3'd1;
         if (phase_ff == PH_TOKEN) begin
            if (pair_bits == TOK_EXT) begin
               phase_in   = PH_EXT;
               tok_in     = '0;
               tok_cnt_in = '0;
            end else begin
               run_in       = RUN_W'(pair_bits) + RUN_W'(1);
               run_color_in = color_ff;
               color_in     = !color_ff;
            end
         end else begin
            tok_in     = ext_val[5:0];
            tok_cnt_in = tok_cnt_ff + 2'd1;
            if (tok_cnt_ff == EXT_LAST_PR) begin
               phase_in     = PH_TOKEN;
               tok_in       = '0;
               tok_cnt_in   = '0;
               run_color_in = color_ff;
               if (ext_val == 8'd0) begin
                  run_in = LONG_RUN;
               end else begin
                  run_in   = RUN_W'(ext_val) + EXT_BIAS;
                  color_in = !color_ff;
               end
            end
         end
      end else if (cmd.chunk) begin
         run_in  = run_ff - RUN_W'(chunk_n);
         pend_in = pend_new;
         col_in  = col_new;
         if (byte_end) begin
            pend_in = '0;
            if (hold_valid_ff) begin
               out_valid_in  = 1'b1;
               out_bvalid_in = 1'b1;
               out_addr_in   = hold_addr_ff;
               out_value_in  = hold_value_ff;
               out_done_in   = hold_done_ff;
               out_err_in    = 1'b0;
               out_last_in   = 1'b0;
            end
            hold_valid_in = 1'b1;
            hold_addr_in  = chunk_addr;
            hold_value_in = pend_new;
            hold_done_in  = row_end && last_row;
         end
         if (row_end) begin
            col_in  = '0;
            row_in  = row_ff + RW'(1);
            base_in = base_ff + ADDR_W'(stride_ff);
            if (last_row) begin
               phase_in = PH_DONE;
               run_in   = '0;
            end
         end
      end else if (cmd.finish) begin
         out_valid_in  = 1'b1;
         out_bvalid_in = hold_valid_ff;
         out_addr_in   = hold_valid_ff ? hold_addr_ff : '0;
         out_value_in  = hold_valid_ff ? hold_value_ff : '0;
         out_done_in   = hold_valid_ff ? hold_done_ff : (phase_ff == PH_DONE);
         out_err_in    = fin_err;
         out_last_in   = 1'b1;
         hold_valid_in = 1'b0;
         if (last_ff) begin
            phase_in   = PH_HEADER;
            color_in   = 1'b0;
            tok_in     = '0;
            tok_cnt_in = '0;
            run_in     = '0;
            col_in     = '0;
            row_in     = '0;
            base_in    = '0;
            pend_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         color_ff      <= 1'b0;
         tok_ff        <= '0;
         tok_cnt_ff    <= '0;
         run_ff        <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         base_ff       <= '0;
         pend_ff       <= '0;
         pairs_ff      <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         color_ff      <= color_in;
         tok_ff        <= tok_in;
         tok_cnt_ff    <= tok_cnt_in;
         run_ff        <= run_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         base_ff       <= base_in;
         pend_ff       <= pend_in;
         pairs_ff      <= pairs_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      last_ff       <= last_in;
      run_color_ff  <= run_color_in;
      w_ff          <= w_in;
      h_ff          <= h_in;
      stride_ff     <= stride_in;
      hold_addr_ff  <= hold_addr_in;
      hold_value_ff <= hold_value_in;
      hold_done_ff  <= hold_done_in;
      out_bvalid_ff <= out_bvalid_in;
      out_addr_ff   <= out_addr_in;
      out_value_ff  <= out_value_in;
      out_done_ff   <= out_done_in;
      out_err_ff    <= out_err_in;
      out_last_ff   <= out_last_in;
   end

   assign status.phase       = phase_ff;
   assign status.run_busy    = (run_ff != '0);
   assign status.pairs_zero  = (pairs_ff == '0);
   assign status.chunk_emits = byte_end;
   assign status.hold_valid  = hold_valid_ff;
   assign status.slot_free   = slot_free;

   assign rsp_valid      = out_valid_ff;
   assign rsp_byte_valid = out_bvalid_ff;
   assign rsp_address    = out_addr_ff;
   assign rsp_value      = out_value_ff;
   assign rsp_done       = out_done_ff;
   assign rsp_error      = out_err_ff;
   assign rsp_last       = out_last_ff;

   `MBRLE_ASSERT_IMP(a_run_only_decoding, run_ff != '0, phase_ff == PH_TOKEN || phase_ff == PH_EXT, "run pending outside token decoding")
   `MBRLE_ASSERT_IMP(a_pend_ahead_clear, phase_ff == PH_TOKEN || phase_ff == PH_EXT, (pend_ff & (8'hFF >> col_ff[2:0])) == 8'h00, "pending byte has bits at or past the column")
   `MBRLE_ASSERT_IMP(a_error_on_last, out_valid_ff && out_err_ff, out_last_ff, "error flag on a result that does not close its transfer")
   `MBRLE_ASSERT_NXT(a_done_sticks, phase_ff == PH_DONE, phase_ff == PH_DONE || phase_ff == PH_HEADER, "finished image left done for a decoding phase")

endmodule
`default_nettype wire

// ===== rtl/mono_bit_rle_bitmap_decoder.sv =====
// Two-bit run-length decoder for a 1bpp bitmap. Compressed bytes come in on req_ch, one per
// transfer; the first byte of a stream gives the start color in bit 0 and latches width,
// height and stride from the registers on csr_ch. Every decoded bitmap byte leaves on rsp_ch
// with its address (row times stride plus column over eight); a byte that completes nothing
// gives one status result, and the final result of each input byte carries last_result and
// any stream error. An input byte is accepted, decoded as header or in four two-bit token
// steps with run chunks between them, and closed by a result; the next byte is taken only
// then. A chunk writes up to eight pixels and ends at a byte, row or run boundary; result
// backpressure stalls chunks through a one-entry hold register and the output register.
`default_nettype none
module mono_bit_rle_bitmap_decoder #(
   parameter int MAX_WIDTH  = mbrle_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = mbrle_pkg::DEF_MAX_HEIGHT
) (
   input wire logic    clock,
   input wire logic    reset,
   mbrle_req_if.sink   req_ch,
   mbrle_rsp_if.source rsp_ch,
   mbrle_csr_if.sink   csr_ch
);
   import mbrle_pkg::*;

   logic [CFG_DATA_W-1:0] cfg_width;
   logic [CFG_DATA_W-1:0] cfg_height;
   logic [STRIDE_W-1:0]   cfg_stride;
   dp_cmd_type            cmd;
   dp_status_type         status;

   mbrle_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .wr_valid   (csr_ch.valid),
      .wr_ready   (csr_ch.ready),
      .wr_index   (csr_ch.reg_index),
      .wr_data    (csr_ch.wr_data),
      .cfg_width  (cfg_width),
      .cfg_height (cfg_height),
      .cfg_stride (cfg_stride)
   );

   mbrle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mbrle_dpath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_data       (req_ch.data_byte),
      .req_last       (req_ch.last_byte),
      .cfg_width      (cfg_width),
      .cfg_height     (cfg_height),
      .cfg_stride     (cfg_stride),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_byte_valid (rsp_ch.byte_valid),
      .rsp_address    (rsp_ch.byte_address),
      .rsp_value      (rsp_ch.byte_value),
      .rsp_done       (rsp_ch.image_done),
      .rsp_error      (rsp_ch.stream_error),
      .rsp_last       (rsp_ch.last_result)
   );

endmodule
`default_nettype wire

// ===== tb/mbrle_tb_pkg.sv =====
// bitmap byte predictor and result checker for the run-length bitmap decoder testbench
`timescale 1ns / 1ps
package mbrle_tb_pkg;
   import mbrle_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int unsigned MAX_OUT_PER_BYTE = 64;
   localparam int unsigned PRINT_CAP = 30;

   typedef struct packed {
      logic              byte_valid;
      logic [ADDR_W-1:0] byte_address;
      logic [BYTE_W-1:0] byte_value;
      logic              image_done;
      logic              stream_error;
      logic              last_result;
   } bitmap_out_t;

   class bitmap_decode_checker;
      logic [CFG_DATA_W-1:0] width_reg;
      logic [CFG_DATA_W-1:0] height_reg;
      logic [STRIDE_W-1:0]   stride_reg;
      phase_type   ph;
      bit          color;
      bit [7:0]    tok_bits;
      int unsigned tok_count;
      int unsigned col;
      int unsigned row;
      bit [7:0]    pend;
      int unsigned img_w;
      int unsigned img_h;
      int unsigned img_stride;
      bitmap_out_t byte_out[$];
      bitmap_out_t awaited[$];
      int unsigned mismatches;
      int unsigned inputs_taken;
      int unsigned results_checked;
      int unsigned images_finished;
      int unsigned streams_failed;

      function new();
         width_reg = RST_WIDTH;
         height_reg = RST_HEIGHT;
         stride_reg = RST_STRIDE;
         img_w = RST_WIDTH;
         img_h = RST_HEIGHT;
         img_stride = RST_STRIDE;
         mismatches = 0;
         inputs_taken = 0;
         results_checked = 0;
         images_finished = 0;
         streams_failed = 0;
         restart_stream();
      endfunction

      function void restart_stream();
         ph = PH_HEADER;
         color = 1'b0;
         tok_bits = '0;
         tok_count = 0;
         col = 0;
         row = 0;
         pend = '0;
      endfunction

      function int unsigned outstanding();
         return awaited.size();
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
         case (idx)
            CSR_WIDTH: width_reg = data;
            CSR_HEIGHT: height_reg = data;
            CSR_STRIDE: stride_reg = data[STRIDE_W-1:0];
            default: ;
         endcase
      endfunction

      function void emit(logic valid, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] value,
                         logic done);
         bitmap_out_t r;
         r = '0;
         r.byte_valid = valid;
         r.byte_address = addr;
         r.byte_value = value;
         r.image_done = done;
         if (byte_out.size() < MAX_OUT_PER_BYTE) byte_out.push_back(r);
      endfunction

      function void put_pixel();
         int unsigned addr;
         pend[7 - (col % 8)] = color;
         col++;
         if (col % 8 == 0 || col >= img_w) begin
            addr = row * img_stride + (col - 1) / 8;
            if (col >= img_w) begin
               col = 0;
               row++;
               if (row >= img_h) ph = PH_DONE;
            end
            emit(1'b1, addr[ADDR_W-1:0], pend, ph == PH_DONE);
            pend = '0;
         end
      endfunction

      function void run_pixels(int unsigned len, bit toggle);
         for (int unsigned k = 0; k < len && ph != PH_DONE; k++) put_pixel();
         if (toggle) color = ~color;
      endfunction

      // works out every result that one accepted compressed byte causes
      function void take_byte(logic [7:0] data, logic last);
         bit          err;
         bit          done_now;
         bit          was_done;
         logic [1:0]  tok;
         logic [7:0]  ext_len;
         bitmap_out_t r;
         byte_out.delete();
         err = 1'b0;
         was_done = (ph == PH_DONE);
         inputs_taken++;
         if (ph == PH_HEADER) begin
            img_w = width_reg;
            if (img_w < MIN_WIDTH) img_w = MIN_WIDTH;
            if (img_w > DEF_MAX_WIDTH) img_w = DEF_MAX_WIDTH;
            img_h = height_reg;
            if (img_h < MIN_HEIGHT) img_h = MIN_HEIGHT;
            if (img_h > DEF_MAX_HEIGHT) img_h = DEF_MAX_HEIGHT;
            img_stride = stride_reg;
            restart_stream();
            color = data[0];
            ph = (img_stride < (img_w + 7) / 8) ? PH_ERROR : PH_TOKEN;
         end else if (ph == PH_TOKEN || ph == PH_EXT) begin
            for (int i = 7; i >= 0; i--) begin
               if (ph != PH_TOKEN && ph != PH_EXT) break;
               tok_bits = {tok_bits[6:0], data[i]};
               tok_count++;
               if (ph == PH_TOKEN && tok_count == 2) begin
                  tok = tok_bits[1:0];
                  tok_bits = '0;
                  tok_count = 0;
                  if (tok == TOK_EXT) ph = PH_EXT;
                  else run_pixels(int'(tok) + 1, 1'b1);
               end else if (ph == PH_EXT && tok_count == 8) begin
                  ext_len = tok_bits;
                  tok_bits = '0;
                  tok_count = 0;
                  ph = PH_TOKEN;
                  if (ext_len == 0) run_pixels(int'(LONG_RUN), 1'b0);
                  else run_pixels(int'(ext_len) + int'(EXT_BIAS), 1'b1);
               end
            end
         end
         done_now = (ph == PH_DONE);
         if (done_now && !was_done) images_finished++;
         if (ph == PH_ERROR) err = 1'b1;
         if (last) begin
            if (ph == PH_TOKEN || ph == PH_EXT) err = 1'b1;
            if (err) streams_failed++;
            restart_stream();
         end
         if (byte_out.size() == 0) emit(1'b0, '0, '0, done_now);
         r = byte_out.pop_back();
         r.stream_error = err;
         r.last_result = 1'b1;
         byte_out.push_back(r);
         foreach (byte_out[k]) awaited.push_back(byte_out[k]);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         mismatches++;
         if (mismatches <= PRINT_CAP)
            $display("%0t ns: result %0d %s got %h want %h", $time, results_checked, what,
                     got, want);
      endtask

      task check_out(bitmap_out_t got);
         bitmap_out_t want;
         results_checked++;
         if (awaited.size() == 0) begin
            report("arrived with nothing pending, address", got.byte_address, '0);
            return;
         end
         want = awaited.pop_front();
         if (got.byte_valid !== want.byte_valid)
            report("byte_valid", got.byte_valid, want.byte_valid);
         if (got.byte_address !== want.byte_address)
            report("byte_address", got.byte_address, want.byte_address);
         if (got.byte_value !== want.byte_value)
            report("byte_value", got.byte_value, want.byte_value);
         if (got.image_done !== want.image_done)
            report("image_done", got.image_done, want.image_done);
         if (got.stream_error !== want.stream_error)
            report("stream_error", got.stream_error, want.stream_error);
         if (got.last_result !== want.last_result)
            report("last_result", got.last_result, want.last_result);
      endtask
   endclass

endpackage

// ===== tb/tb_top.sv =====
// top of the run-length bitmap decoder testbench: clock, reset, stimulus and result checks
`timescale 1ns / 1ps
module tb_top;
   import mbrle_pkg::*;
   import mbrle_tb_pkg::*;

   localparam int unsigned ITEM_GOAL = 410;
   localparam int unsigned LONG_HOLD = 400;
   localparam int unsigned TAIL_WAIT = 16;

   logic clock;
   logic reset;

   mbrle_req_if req_ch ();
   mbrle_rsp_if rsp_ch ();
   mbrle_csr_if csr_ch ();

   bitmap_decode_checker chk;
   int unsigned items_sent;
   int unsigned reg_writes;
   int unsigned hold_cycles;
   bit          gaps_on;
   bit          stalls_on;

   mono_bit_rle_bitmap_decoder dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("timeout with %0d results still pending", chk.outstanding());
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_byte(input logic [7:0] data, input logic last);
      int unsigned gap;
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= data;
      req_ch.last_byte <= last;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      chk.take_byte(data, last);
      items_sent++;
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (chk.outstanding() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.reg_index <= idx;
      csr_ch.wr_data <= data;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      chk.write_reg(idx, data);
      reg_writes++;
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_config(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                               input logic [CFG_DATA_W-1:0] s);
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
      write_reg(CSR_STRIDE, s);
   endtask

   // well-formed token stream covering the image, optionally cut short or padded with junk
   task automatic send_coded_image(input int unsigned pixels, input bit damaged,
                                   input bit pause_mid);
      bit          bits[$];
      logic [7:0]  seq[$];
      logic [7:0]  b;
      logic [7:0]  ext_len;
      logic [1:0]  tok;
      int unsigned have;
      int unsigned body;
      int unsigned stop;
      bit          use_ext;
      seq.push_back(8'($urandom));
      have = 0;
      while (have < pixels) begin
         if (pixels - have > 40) use_ext = ($urandom_range(0, 3) != 0);
         else use_ext = ($urandom_range(0, 9) == 0);
         if (use_ext) begin
            ext_len = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            bits.push_back(TOK_EXT[1]);
            bits.push_back(TOK_EXT[0]);
            for (int i = 7; i >= 0; i--) bits.push_back(ext_len[i]);
            have += (ext_len == 0) ? int'(LONG_RUN) : int'(ext_len) + int'(EXT_BIAS);
         end else begin
            tok = 2'($urandom_range(0, 2));
            bits.push_back(tok[1]);
            bits.push_back(tok[0]);
            have += int'(tok) + 1;
         end
      end
      while (bits.size() % 8 != 0) bits.push_back(bit'($urandom_range(0, 1)));
      while (bits.size() != 0) begin
         for (int i = 7; i >= 0; i--) b[i] = bits.pop_front();
         seq.push_back(b);
      end
      body = seq.size();
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) seq.push_back(8'($urandom));
      stop = damaged ? $urandom_range(1, body - 1) : seq.size();
      for (int unsigned i = 0; i < stop; i++) begin
         if (pause_mid && i == stop / 2) settle();
         send_byte(seq[i], i == stop - 1);
      end
   endtask

   task automatic send_noise();
      int unsigned n;
      n = $urandom_range(2, 12);
      for (int unsigned i = 0; i < n; i++)
         send_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 9) == 0));
   endtask

   task automatic run_directed();
      write_config(12'd16, 12'd2, 12'd2);
      send_byte(8'h01, 1'b0);
      send_byte(8'h1B, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hA5, 1'b1);
      settle();
      // widest row, stride just large enough, long run without toggle, cut mid extension
      write_config(12'd2048, 12'd1, 12'd256);
      send_byte(8'h00, 1'b0);
      send_byte(8'hC0, 1'b0);
      send_byte(8'h3C, 1'b1);
      settle();
      write_reg(CSR_STRIDE, 12'd255);
      send_byte(8'h01, 1'b0);
      send_byte(8'hFF, 1'b1);
      settle();
      // out of range registers clamp to 16 x 1
      write_config(12'd0, 12'd0, 12'hFFF);
      send_byte(8'h00, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h55, 1'b1);
      settle();
      write_reg(CSR_SPARE, 12'hABC);
      send_byte(8'hFE, 1'b1);
      settle();
      write_config(12'hFFF, 12'hFFF, 12'h100);
      send_byte(8'h00, 1'b0);
      send_byte(8'h8F, 1'b0);
      send_byte(8'hFF, 1'b1);
      settle();
   endtask

   initial begin : result_sink
      bitmap_out_t got;
      int unsigned stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_cycles != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         stall = stalls_on ? $urandom_range(0, 6) : 0;
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         got.byte_valid = rsp_ch.byte_valid;
         got.byte_address = rsp_ch.byte_address;
         got.byte_value = rsp_ch.byte_value;
         got.image_done = rsp_ch.image_done;
         got.stream_error = rsp_ch.stream_error;
         got.last_result = rsp_ch.last_result;
         chk.check_out(got);
      end
   end

   initial begin : stimulus
      int unsigned w;
      int unsigned h;
      int unsigned s;
      int unsigned pick;
      int unsigned pixels;
      int unsigned streams;
      int unsigned phase_no;
      chk = new();
      items_sent = 0;
      reg_writes = 0;
      hold_cycles = 0;
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      phase_no = 0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data_byte <= '0;
      req_ch.last_byte <= 1'b0;
      csr_ch.valid <= 1'b0;
      csr_ch.reg_index <= CSR_WIDTH;
      csr_ch.wr_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      while (items_sent < ITEM_GOAL) begin
         settle();
         pick = $urandom_range(0, 15);
         w = $urandom_range(16, 40);
         h = $urandom_range(1, 5);
         s = (w + 7) / 8 + $urandom_range(0, 3);
         if (phase_no == 0) begin
            w = 32;
            h = 6;
            s = 4;
         end else if (pick == 0) begin
            w = $urandom_range(200, 2048);
            h = 1;
            s = 256;
         end else if (pick == 1) begin
            w = 16;
            h = $urandom_range(8, 14);
            s = 2;
         end else if (pick == 2) begin
            s = (w + 7) / 8 - 1;
         end else if (pick == 3) begin
            w = $urandom_range(0, 15);
            h = 0;
            s = $urandom_range(2, 4);
         end
         write_config(w[CFG_DATA_W-1:0], h[CFG_DATA_W-1:0], s[CFG_DATA_W-1:0]);
         pixels = (w < MIN_WIDTH ? MIN_WIDTH : w) * (h < MIN_HEIGHT ? MIN_HEIGHT : h);
         gaps_on = (phase_no >= 2) && ($urandom_range(0, 3) != 0);
         stalls_on = (phase_no >= 2) && ($urandom_range(0, 3) != 0);
         // long receiver hold while the sender keeps pushing
         if (phase_no == 0) hold_cycles = LONG_HOLD;
         streams = $urandom_range(2, 4);
         for (int unsigned k = 0; k < streams; k++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) send_noise();
            else send_coded_image(pixels, pick == 1, phase_no == 1 && k == 0);
         end
         phase_no++;
      end
      settle();
      $display("%0d compressed bytes in, %0d results checked, %0d register writes",
               chk.inputs_taken, chk.results_checked, reg_writes);
      $display("%0d images decoded to the end, %0d streams closed with an error",
               chk.images_finished, chk.streams_failed);
      if (chk.mismatches == 0 && chk.outstanding() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
